### rtl/queued_velocity_step_generator_unit_macros.svh
// assertion macros for the queued velocity step generator
`ifndef QUEUED_VELOCITY_STEP_GENERATOR_UNIT_MACROS_SVH
`define QUEUED_VELOCITY_STEP_GENERATOR_UNIT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define QVSG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never be seen outside reset
`define QVSG_ASSERT_NEVER(label, expr, msg) \
  `QVSG_ASSERT_IMPLY(label, 1'b1, !(expr), msg)

`endif

### rtl/qvsg_pkg.sv
// shared types and constants of the queued velocity step generator
`timescale 1ns / 1ps

package qvsg_pkg;

  localparam int QUEUE_DEPTH_DEF = 5;

  localparam int VEL_W   = 24;
  localparam int MAG_W   = 24;
  localparam int HOLD_W  = 32;
  localparam int GEAR_W  = 16;
  localparam int THR_W   = 48;
  localparam int PW_W    = 8;
  localparam int POS_W   = 32;
  localparam int TMR_W   = 32;
  localparam int QC_W    = 3;
  localparam int CFG_IDX_W = 2;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GEAR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWIDTH = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  localparam logic [GEAR_W-1:0] GEAR_RST   = 16'd256;
  localparam logic [THR_W-1:0]  THRESH_RST = 48'd0;
  localparam logic [PW_W-1:0]   PWIDTH_RST = 8'd10;

  localparam logic [MAG_W-1:0] MAG_POS_MAX = 24'h7FFFFF;
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = 24'h800000;

  // velocity kept as sign and magnitude, neg only set for nonzero values
  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [HOLD_W-1:0] hold;
  } seg_t;

  typedef struct packed {
    logic op;
    seg_t seg;
  } cmd_t;

  typedef struct packed {
    logic             step_pulse;
    logic             direction;
    logic [POS_W-1:0] position_steps;
    logic [QC_W-1:0]  queued_count;
    logic             push_dropped;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/qvsg_front.sv
// front end: accepts items, scales pushed velocities by the gear factor
`timescale 1ns / 1ps

module qvsg_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic signed [qvsg_pkg::VEL_W-1:0] in_vel,
  input  logic [qvsg_pkg::HOLD_W-1:0]    in_hold,
  input  logic [qvsg_pkg::GEAR_W-1:0]    gear,
  input  logic                           q_full,
  output logic                           fr_valid,
  output qvsg_pkg::cmd_t                 fr_cmd
);

  localparam int PROD_W = qvsg_pkg::MAG_W + qvsg_pkg::GEAR_W;

  logic                       fr_valid_r;
  qvsg_pkg::cmd_t             fr_cmd_r;
  qvsg_pkg::cmd_t             cmd_nxt;
  logic [qvsg_pkg::VEL_W-1:0] vel_u;
  logic [qvsg_pkg::MAG_W-1:0] raw_mag;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-9:0]          scaled;
  logic [qvsg_pkg::MAG_W-1:0] sat_mag;
  logic                       advance;

  assign vel_u   = in_vel;
  assign raw_mag = vel_u[qvsg_pkg::VEL_W-1] ? (~vel_u + 24'd1) : vel_u;
  assign prod    = PROD_W'(raw_mag) * PROD_W'(gear);
  // q8.8 gear factor, fraction dropped
  assign scaled  = prod[PROD_W-1:8];

  always_comb begin
    if (vel_u[qvsg_pkg::VEL_W-1]) begin
      sat_mag = (scaled > 32'(qvsg_pkg::MAG_NEG_MAX)) ? qvsg_pkg::MAG_NEG_MAX
                                                       : scaled[qvsg_pkg::MAG_W-1:0];
    end else begin
      sat_mag = (scaled > 32'(qvsg_pkg::MAG_POS_MAX)) ? qvsg_pkg::MAG_POS_MAX
                                                       : scaled[qvsg_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    cmd_nxt          = '0;
    cmd_nxt.op       = in_op;
    cmd_nxt.seg.mag  = sat_mag;
    cmd_nxt.seg.neg  = vel_u[qvsg_pkg::VEL_W-1] && (sat_mag != '0);
    cmd_nxt.seg.hold = in_hold;
  end

  assign advance  = !fr_valid_r || !q_full;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (advance) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      fr_cmd_r <= cmd_nxt;
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_cmd   = fr_cmd_r;

endmodule

### rtl/qvsg_cmd_queue.sv
// short command queue between front end and execution back end
`timescale 1ns / 1ps

module qvsg_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  qvsg_pkg::cmd_t    wr_data,
  output logic              rd_valid,
  input  logic              rd_take,
  output qvsg_pkg::cmd_t    rd_data,
  output qvsg_pkg::q_stat_t stat
);

  localparam int PTR_W = (qvsg_pkg::CMDQ_DEPTH > 1) ? $clog2(qvsg_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(qvsg_pkg::CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(qvsg_pkg::CMDQ_DEPTH - 1);

  qvsg_pkg::cmd_t   entry_r [qvsg_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign stat.full  = (count_r == CNT_W'(qvsg_pkg::CMDQ_DEPTH));
  assign stat.empty = (count_r == '0);
  assign push       = wr_valid && !stat.full;
  assign pop        = rd_take && !stat.empty;
  assign rd_valid   = !stat.empty;
  assign rd_data    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/qvsg_back.sv
// back end: segment fifo, timers, step decision and result register
`timescale 1ns / 1ps

module qvsg_back #(
  parameter int QUEUE_DEPTH = qvsg_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  qvsg_pkg::cmd_t               cmd,
  output logic                         cmd_take,
  input  logic [qvsg_pkg::THR_W-1:0]   step_threshold,
  input  logic [qvsg_pkg::PW_W-1:0]    pulse_width,
  output logic                         out_valid,
  input  logic                         out_ready,
  output qvsg_pkg::res_t               out_res,
  output logic [CNT_W-1:0]             seg_count
);

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PROD_W = qvsg_pkg::TMR_W + qvsg_pkg::MAG_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(QUEUE_DEPTH - 1);

  // segment store, read port registered at the next head address
  qvsg_pkg::seg_t seg_mem [QUEUE_DEPTH];
  qvsg_pkg::seg_t head_seg_r;

  logic [IDX_W-1:0]            head_r, head_nxt;
  logic [IDX_W-1:0]            tail_r, tail_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        cur_neg_r, cur_neg_nxt;
  logic [qvsg_pkg::MAG_W-1:0]  cur_mag_r, cur_mag_nxt;
  logic [qvsg_pkg::HOLD_W-1:0] cur_hold_r, cur_hold_nxt;
  logic [qvsg_pkg::TMR_W-1:0]  hold_tmr_r, hold_tmr_nxt;
  logic [qvsg_pkg::TMR_W-1:0]  elapsed_r, elapsed_nxt;
  logic                        pulse_r, pulse_nxt;
  logic                        dir_r, dir_nxt;
  logic [qvsg_pkg::POS_W-1:0]  steps_r, steps_nxt;
  logic                        out_valid_r;
  qvsg_pkg::res_t              out_res_r;

  logic                        exec;
  logic                        is_push;
  logic                        full;
  logic                        we;
  logic                        dropped;
  logic [qvsg_pkg::TMR_W-1:0]  hold1;
  logic [qvsg_pkg::TMR_W-1:0]  el1;
  logic                        pop;
  logic [qvsg_pkg::MAG_W-1:0]  mag_use;
  logic                        neg_use;
  logic [PROD_W-1:0]           prod;
  logic                        do_step;
  logic                        lower;
  logic [CNT_W+qvsg_pkg::QC_W-1:0] cnt_ext;

  assign exec     = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_take = exec;
  assign is_push  = (cmd.op == qvsg_pkg::OP_PUSH);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign we       = exec && is_push && !full;

  // saturating microsecond timers
  assign hold1 = (&hold_tmr_r) ? hold_tmr_r : hold_tmr_r + 1'b1;
  assign el1   = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;

  assign pop     = (hold1 > cur_hold_r) && (count_r != '0);
  assign mag_use = pop ? head_seg_r.mag : cur_mag_r;
  assign neg_use = pop ? head_seg_r.neg : cur_neg_r;
  assign prod    = PROD_W'(el1) * PROD_W'(mag_use);
  assign do_step = (mag_use != '0) && (prod > PROD_W'(step_threshold));
  assign lower   = pulse_r && (el1 >= qvsg_pkg::TMR_W'(pulse_width));

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    cur_neg_nxt  = cur_neg_r;
    cur_mag_nxt  = cur_mag_r;
    cur_hold_nxt = cur_hold_r;
    hold_tmr_nxt = hold_tmr_r;
    elapsed_nxt  = elapsed_r;
    pulse_nxt    = pulse_r;
    dir_nxt      = dir_r;
    steps_nxt    = steps_r;
    dropped      = 1'b0;
    if (exec) begin
      if (is_push) begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          tail_nxt  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        hold_tmr_nxt = hold1;
        elapsed_nxt  = el1;
        if (pop) begin
          cur_neg_nxt  = head_seg_r.neg;
          cur_mag_nxt  = head_seg_r.mag;
          cur_hold_nxt = head_seg_r.hold;
          head_nxt     = (head_r == LAST) ? '0 : head_r + 1'b1;
          count_nxt    = count_r - 1'b1;
          hold_tmr_nxt = '0;
          // zero velocity keeps the previous direction
          if (head_seg_r.mag != '0) begin
            dir_nxt = !head_seg_r.neg;
          end
        end
        if (lower) begin
          pulse_nxt = 1'b0;
        end
        if (do_step) begin
          pulse_nxt   = 1'b1;
          elapsed_nxt = '0;
          steps_nxt   = neg_use ? steps_r - 1'b1 : steps_r + 1'b1;
        end
      end
    end
  end

  assign cnt_ext = {{qvsg_pkg::QC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cur_neg_r   <= 1'b0;
      cur_mag_r   <= '0;
      cur_hold_r  <= '0;
      hold_tmr_r  <= '0;
      elapsed_r   <= '0;
      pulse_r     <= 1'b0;
      dir_r       <= 1'b0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      cur_neg_r  <= cur_neg_nxt;
      cur_mag_r  <= cur_mag_nxt;
      cur_hold_r <= cur_hold_nxt;
      hold_tmr_r <= hold_tmr_nxt;
      elapsed_r  <= elapsed_nxt;
      pulse_r    <= pulse_nxt;
      dir_r      <= dir_nxt;
      steps_r    <= steps_nxt;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_res_r.step_pulse     <= pulse_nxt;
      out_res_r.direction      <= dir_nxt;
      out_res_r.position_steps <= steps_nxt;
      out_res_r.queued_count   <= cnt_ext[qvsg_pkg::QC_W-1:0];
      out_res_r.push_dropped   <= dropped;
    end
  end

  // write into the tail, bypass when the tail is also the next head
  always_ff @(posedge clk) begin
    if (we) begin
      seg_mem[tail_r] <= cmd.seg;
    end
    head_seg_r <= (we && (tail_r == head_nxt)) ? cmd.seg : seg_mem[head_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign seg_count = count_r;

endmodule

### rtl/queued_velocity_step_generator_unit.sv
// top level of the queued velocity step generator
`timescale 1ns / 1ps
// usage
//   in_*  : one item per handshake; tuser[0] = operation (0 tick, 1 push),
//           tdata carries velocity (signed q12.12) and hold time (microseconds)
//   out_* : exactly one result item per input item, in order
//   cfg_* : register writes (gear multiplier, step threshold, pulse width),
//           always ready, only to be written while the block is idle
// throughput: one item per clock, sustained while out_tready is high; the figure
//   is set by the tick path of the back end, where the saturating timer update,
//   a 32 x 24 multiply and the 56-bit threshold compare are all combinational
// path: each item is registered in the front register, then in the command
//   queue, then in the result register
// a stalled receiver holds the result register; the two-entry command queue
//   and the front register fill up before in_tready drops; once out_tready returns
//   results flow at full rate at once and in_tready rises in the cycle after
// reset (rst_n low, synchronous): segment fifo empty, timers, position and
//   pulse cleared, registers back to gear 256, threshold 0, pulse width 10;
//   segment store contents are not cleared and need no clearing pass

`include "queued_velocity_step_generator_unit_macros.svh"

module queued_velocity_step_generator_unit #(
  parameter int QUEUE_DEPTH = qvsg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // velocity [23:0], hold_time [55:24]
  input  logic [0:0]  in_tuser,   // operation [0]
  // result item channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // step_pulse [0], direction [1],
                                  // position_steps [33:2], queued_count [36:34],
                                  // push_dropped [37], zero fill [39:38]
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [qvsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qvsg_pkg::THR_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [qvsg_pkg::GEAR_W-1:0] gear_r;
  logic [qvsg_pkg::THR_W-1:0]  thresh_r;
  logic [qvsg_pkg::PW_W-1:0]   pwidth_r;

  logic              fr_valid;
  qvsg_pkg::cmd_t    fr_cmd;
  qvsg_pkg::q_stat_t q_stat;
  logic              q_valid;
  logic              q_take;
  qvsg_pkg::cmd_t    q_cmd;
  qvsg_pkg::res_t    res;
  logic [CNT_W-1:0]  seg_count;
  logic              seg_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r   <= qvsg_pkg::GEAR_RST;
      thresh_r <= qvsg_pkg::THRESH_RST;
      pwidth_r <= qvsg_pkg::PWIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qvsg_pkg::CFG_GEAR:   gear_r   <= cfg_data[qvsg_pkg::GEAR_W-1:0];
        qvsg_pkg::CFG_THRESH: thresh_r <= cfg_data;
        qvsg_pkg::CFG_PWIDTH: pwidth_r <= cfg_data[qvsg_pkg::PW_W-1:0];
        default: begin
          // index outside the register list, write ignored
        end
      endcase
    end
  end

  // front: accept and scale
  qvsg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser[0]),
    .in_vel   (in_tdata[23:0]),
    .in_hold  (in_tdata[55:24]),
    .gear     (gear_r),
    .q_full   (q_stat.full),
    .fr_valid (fr_valid),
    .fr_cmd   (fr_cmd)
  );

  // decoupling queue
  qvsg_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_data  (fr_cmd),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_cmd),
    .stat     (q_stat)
  );

  // back: execute against segment fifo and timers
  qvsg_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_valid),
    .cmd            (q_cmd),
    .cmd_take       (q_take),
    .step_threshold (thresh_r),
    .pulse_width    (pwidth_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_res        (res),
    .seg_count      (seg_count)
  );

  assign out_tdata = {2'b00, res.push_dropped, res.queued_count, res.position_steps,
                      res.direction, res.step_pulse};

  assign seg_full = (seg_count == CNT_W'(QUEUE_DEPTH));

  // segment fifo never holds more than its depth
  `QVSG_ASSERT_NEVER(a_seg_count_max, seg_count > CNT_W'(QUEUE_DEPTH), "segment count over depth")
  // a dropped push is only reported while the segment fifo is full
  `QVSG_ASSERT_IMPLY(a_drop_full, out_tvalid && res.push_dropped, seg_full, "drop while not full")
  // command queue status stays consistent
  `QVSG_ASSERT_NEVER(a_q_stat, q_stat.full && q_stat.empty, "command queue full and empty")

endmodule

### tb/tb_top.sv
// self-checking bench for the queued velocity step generator unit
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH          = qvsg_pkg::QUEUE_DEPTH_DEF;
  localparam int VEL_W          = qvsg_pkg::VEL_W;
  localparam int HOLD_W         = qvsg_pkg::HOLD_W;
  localparam int GEAR_W         = qvsg_pkg::GEAR_W;
  localparam int THR_W          = qvsg_pkg::THR_W;
  localparam int PW_W           = qvsg_pkg::PW_W;
  localparam int POS_W          = qvsg_pkg::POS_W;
  localparam int TMR_W          = qvsg_pkg::TMR_W;
  localparam int QC_W           = qvsg_pkg::QC_W;
  localparam int CFG_IDX_W      = qvsg_pkg::CFG_IDX_W;
  // input handshake to earliest result handshake
  localparam int LATENCY        = 3;
  localparam int SQUEEZE_CYCLES = 300;
  // slowest correct gap: sender gap, receiver stall, latency, drain pause,
  // or the long receiver hold-off, all taken several times over
  localparam int WATCHDOG_LIMIT = 4000;

  // one item on the input channel
  typedef struct packed {
    logic              op;
    logic [VEL_W-1:0]  vel;
    logic [HOLD_W-1:0] hold;
  } motor_cmd_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata   = '0;  // velocity [23:0], hold_time [55:24]
  logic [0:0]           in_tuser   = '0;  // operation [0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;        // step_pulse [0], direction [1],
                                          // position_steps [33:2], queued_count [36:34],
                                          // push_dropped [37]
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [THR_W-1:0]     cfg_data   = '0;

  // items waiting to be driven, and the motor status predicted per accepted item
  motor_cmd_t     queued_motor_cmds[$];
  qvsg_pkg::res_t predicted_status[$];

  int mismatches   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // driver and receiver idling
  int tx_wait      = 0;
  bit tx_burst     = 1'b0;
  int rx_wait      = 0;
  bit rx_burst     = 1'b0;
  int squeeze_left = 0;
  bit squeeze_done = 1'b0;

  // predictor: registers and motor state
  logic [GEAR_W-1:0] m_gear;
  logic [THR_W-1:0]  m_thresh;
  logic [PW_W-1:0]   m_pwidth;
  logic [VEL_W-1:0]  seg_vel[DEPTH];
  logic [HOLD_W-1:0] seg_hold[DEPTH];
  int                seg_count;
  int                seg_head;
  logic [VEL_W-1:0]  cur_vel;
  logic [HOLD_W-1:0] cur_hold;
  logic [TMR_W-1:0]  hold_tmr;
  logic [TMR_W-1:0]  since_step;
  logic              pulse_lvl;
  logic              dir_lvl;
  logic [POS_W-1:0]  step_pos;

  always #2 clk = ~clk;

  queued_velocity_step_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // motor predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_motor_model();
    m_gear     = qvsg_pkg::GEAR_RST;
    m_thresh   = qvsg_pkg::THRESH_RST;
    m_pwidth   = qvsg_pkg::PWIDTH_RST;
    seg_count  = 0;
    seg_head   = 0;
    cur_vel    = '0;
    cur_hold   = '0;
    hold_tmr   = '0;
    since_step = '0;
    pulse_lvl  = 1'b0;
    dir_lvl    = 1'b0;
    step_pos   = '0;
  endfunction

  // magnitude of a two's complement q12.12 value, 0x800000 stays representable
  function automatic logic [24:0] vel_magnitude(logic [VEL_W-1:0] v);
    return v[VEL_W-1] ? 25'h1000000 - {1'b0, v} : {1'b0, v};
  endfunction

  // gear scaling in q8.8, truncated toward zero and saturated to 24 bits
  function automatic logic [VEL_W-1:0] scale_push_velocity(logic [VEL_W-1:0] raw);
    logic [63:0] mag;
    mag = (64'(vel_magnitude(raw)) * 64'(m_gear)) >> 8;
    if (raw[VEL_W-1]) begin
      if (mag > 64'h800000) mag = 64'h800000;
      return VEL_W'(25'h1000000 - 25'(mag));
    end
    if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
    return VEL_W'(mag);
  endfunction

  // one microsecond: timers, segment pop, pulse lowering, step decision
  function automatic void advance_one_tick();
    logic [55:0] travel;
    if (hold_tmr != '1) hold_tmr++;
    if (since_step != '1) since_step++;
    if (hold_tmr > cur_hold && seg_count > 0) begin
      cur_vel  = seg_vel[seg_head];
      cur_hold = seg_hold[seg_head];
      seg_head = (seg_head + 1) % DEPTH;
      seg_count--;
      hold_tmr = '0;
      // a zero-velocity segment leaves the direction as it was
      if (cur_vel != '0) dir_lvl = ~cur_vel[VEL_W-1];
    end
    if (pulse_lvl && since_step >= TMR_W'(m_pwidth)) pulse_lvl = 1'b0;
    if (cur_vel != '0) begin
      travel = 56'(since_step) * 56'(vel_magnitude(cur_vel));
      if (travel > 56'(m_thresh)) begin
        pulse_lvl  = 1'b1;
        step_pos   = cur_vel[VEL_W-1] ? step_pos - 1'b1 : step_pos + 1'b1;
        since_step = '0;
      end
    end
  endfunction

  function automatic qvsg_pkg::res_t apply_motor_item(motor_cmd_t cmd);
    qvsg_pkg::res_t r;
    int             slot;
    r.push_dropped = 1'b0;
    if (cmd.op == qvsg_pkg::OP_PUSH) begin
      // a push neither advances time nor pops
      if (seg_count >= DEPTH) begin
        r.push_dropped = 1'b1;
      end else begin
        slot           = (seg_head + seg_count) % DEPTH;
        seg_vel[slot]  = scale_push_velocity(cmd.vel);
        seg_hold[slot] = cmd.hold;
        seg_count++;
      end
    end else begin
      advance_one_tick();
    end
    r.step_pulse     = pulse_lvl;
    r.direction      = dir_lvl;
    r.position_steps = step_pos;
    r.queued_count   = QC_W'(seg_count);
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued items, random gap after each accepted one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    motor_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
        tx_wait = tx_burst ? 0 : $urandom_range(0, 19);
      end
      if (in_tvalid && !in_tready) begin
        // item still on offer, hold it
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_tvalid <= 1'b0;
      end else if (queued_motor_cmds.size() != 0) begin
        nxt = queued_motor_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.hold, nxt.vel};
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: register writes, predictions, result checks, receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    qvsg_pkg::res_t seen;
    qvsg_pkg::res_t want;
    motor_cmd_t     taken;
    if (!rst_n) begin
      reset_motor_model();
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qvsg_pkg::CFG_GEAR:   m_gear   = cfg_data[GEAR_W-1:0];
          qvsg_pkg::CFG_THRESH: m_thresh = cfg_data;
          qvsg_pkg::CFG_PWIDTH: m_pwidth = cfg_data[PW_W-1:0];
          default: ;
        endcase
      end

      // results leave in order, so the oldest prediction is the one to match
      if (out_tvalid && out_tready) begin
        seen.step_pulse     = out_tdata[0];
        seen.direction      = out_tdata[1];
        seen.position_steps = out_tdata[33:2];
        seen.queued_count   = out_tdata[36:34];
        seen.push_dropped   = out_tdata[37];
        results_seen++;
        if (predicted_status.size() == 0) begin
          $error("result item with no prediction waiting: %h", out_tdata);
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          check_field("step_pulse", 32'(want.step_pulse), 32'(seen.step_pulse));
          check_field("direction", 32'(want.direction), 32'(seen.direction));
          check_field("position_steps", want.position_steps, seen.position_steps);
          check_field("queued_count", 32'(want.queued_count), 32'(seen.queued_count));
          check_field("push_dropped", 32'(want.push_dropped), 32'(seen.push_dropped));
        end
        if ($urandom_range(0, 31) == 0) rx_burst = ~rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
      end

      if (in_tvalid && in_tready) begin
        taken.op   = in_tuser[0];
        taken.vel  = in_tdata[VEL_W-1:0];
        taken.hold = in_tdata[55:24];
        predicted_status.push_back(apply_motor_item(taken));
      end

      // one long hold-off while items are still queued, so the block backs up
      if (!squeeze_done && results_seen >= 150 && queued_motor_cmds.size() > 30) begin
        squeeze_left = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end

      if (squeeze_left > 0) begin
        squeeze_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("queued_velocity_step_generator_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [VEL_W-1:0] random_velocity();
    logic [VEL_W-1:0] mag;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return qvsg_pkg::MAG_POS_MAX;
      2: return qvsg_pkg::MAG_NEG_MAX;
      default: begin
        mag = VEL_W'($urandom) >> $urandom_range(1, 23);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic void add_push(logic [VEL_W-1:0] vel, logic [HOLD_W-1:0] hold);
    queued_motor_cmds.push_back('{op: qvsg_pkg::OP_PUSH, vel: vel, hold: hold});
  endfunction

  // tick items carry random payload, which the block must ignore
  function automatic void add_ticks(int n);
    repeat (n)
      queued_motor_cmds.push_back('{op: qvsg_pkg::OP_TICK, vel: VEL_W'($urandom),
                                    hold: $urandom});
  endfunction

  // mostly whole motion profiles (segments then ticks), some noise
  function automatic void add_motion_phase(int n_items);
    int start;
    start = queued_motor_cmds.size();
    while (queued_motor_cmds.size() - start < n_items) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          repeat (10) begin
            if ($urandom_range(0, 1) == 1) add_push(VEL_W'($urandom), $urandom_range(0, 40));
            else add_ticks(1);
          end
        end
        9: begin
          add_push(random_velocity(), $urandom_range(100, 400));
          add_ticks($urandom_range(20, 120));
          repeat ($urandom_range(1, 6)) add_push(random_velocity(), $urandom_range(0, 25));
          add_ticks($urandom_range(20, 80));
        end
        default: begin
          // six pushes now and then, so an overfull queue drops one
          repeat ($urandom_range(1, 6)) add_push(random_velocity(), $urandom_range(0, 25));
          add_ticks($urandom_range(5, 60));
        end
      endcase
    end
  endfunction

  // wait for every result, then for the pipeline to settle
  task automatic await_motor_idle();
    do @(negedge clk);
    while (queued_motor_cmds.size() != 0 || in_tvalid || predicted_status.size() != 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [GEAR_W-1:0] gear, logic [THR_W-1:0] thr,
                           logic [PW_W-1:0] pw);
    write_reg(qvsg_pkg::CFG_GEAR, THR_W'(gear));
    write_reg(qvsg_pkg::CFG_THRESH, thr);
    write_reg(qvsg_pkg::CFG_PWIDTH, THR_W'(pw));
    @(negedge clk);
  endtask

  task automatic configure_random();
    logic [GEAR_W-1:0] gear;
    logic [THR_W-1:0]  thr;
    logic [PW_W-1:0]   pw;
    gear = ($urandom_range(0, 3) == 0) ? GEAR_W'($urandom) : GEAR_W'($urandom_range(64, 1024));
    thr  = {16'($urandom), 32'($urandom)} >> $urandom_range(10, 47);
    pw   = ($urandom_range(0, 3) == 0) ? PW_W'($urandom) : PW_W'($urandom_range(1, 12));
    configure(gear, thr, pw);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset settings: extremes of velocity, zero velocity, overfull queue
    add_push(qvsg_pkg::MAG_POS_MAX, 32'd2);
    add_push(qvsg_pkg::MAG_NEG_MAX, 32'd1);
    add_push('0, 32'd0);
    add_push('1, 32'd3);
    add_push(24'd1, 32'd0);
    add_push(24'h123456, '1);   // queue full, dropped
    add_ticks(18);
    await_motor_idle();

    // extreme settings: saturating gear with zero pulse width, then zero gear
    // with the largest threshold, then unity gear with the widest pulse
    configure('1, '0, '0);
    add_motion_phase(80);
    await_motor_idle();
    configure('0, '1, 8'd1);
    add_motion_phase(60);
    await_motor_idle();
    configure(qvsg_pkg::GEAR_RST, 48'd40000, '1);
    add_motion_phase(80);
    await_motor_idle();

    repeat (3) begin
      configure_random();
      add_motion_phase(80);
      await_motor_idle();
    end

    // last of all a segment held for the longest time, after which the queue
    // only fills and drops
    configure_random();
    add_ticks(10);
    add_push(random_velocity(), '1);
    add_ticks(20);
    repeat (7) add_push(random_velocity(), $urandom);
    add_ticks(10);
    await_motor_idle();

    if (mismatches == 0) begin
      $display("queued_velocity_step_generator_unit regression: pass");
    end else begin
      $display("queued_velocity_step_generator_unit regression: fail");
    end
    $finish;
  end

endmodule

### queued_velocity_step_generator_unit.f
+incdir+rtl
rtl/qvsg_pkg.sv
rtl/qvsg_front.sv
rtl/qvsg_cmd_queue.sv
rtl/qvsg_back.sv
rtl/queued_velocity_step_generator_unit.sv
tb/tb_top.sv
